>>> hw/rtl/atsc_pkg.sv
`default_nettype none

package atsc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROOT_BITS = 20;

    localparam logic [15:0] NINE_TENTHS_Q = 16'd58982;
    localparam logic [17:0] FACTOR_LOW_Q  = 18'd6554;
    localparam logic [17:0] FACTOR_HIGH_Q = 18'd131072;

    localparam logic [31:0] STEP_MIN_RESET = 32'd1;
    localparam logic [31:0] STEP_MAX_RESET = 32'd65536;
    localparam logic [31:0] SAFETY_RESET   = 32'd32768;

    typedef enum logic [1:0] {
        CFG_STEP_MIN = 2'd0,
        CFG_STEP_MAX = 2'd1,
        CFG_SAFETY   = 2'd2
    } cfg_index_t;

    // Control and side data that travels alongside every pipeline stage.
    typedef struct packed {
        logic        valid;
        logic        mode;
        logic        zero;
        logic [31:0] cur;
    } side_t;

    typedef struct packed {
        logic [31:0] step_minimum;
        logic [31:0] step_maximum;
    } bounds_t;

endpackage

`default_nettype wire

>>> hw/rtl/atsc_div.sv
`default_nettype none

module atsc_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire atsc_pkg::side_t side_in,
    input  wire logic [63:0]     dividend,
    input  wire logic [31:0]     divisor,
    output atsc_pkg::side_t      side_out,
    output logic [31:0]          quot
);

    typedef struct packed {
        atsc_pkg::side_t side;
        logic            sat;
        logic [31:0]     rem;
        logic [31:0]     quo;
        logic [31:0]     dsr;
    } div_t;

    div_t stage_reg  [0:atsc_pkg::WORD_W];
    div_t stage_next [0:atsc_pkg::WORD_W];

    // A quotient that does not fit in 32 bits shows as a high half not below the divisor.
    always_comb
    begin
        stage_next[0].side = side_in;
        stage_next[0].sat  = (dividend[63:32] >= divisor);
        stage_next[0].rem  = dividend[63:32];
        stage_next[0].quo  = dividend[31:0];
        stage_next[0].dsr  = divisor;
    end

    for (genvar k = 0; k < atsc_pkg::WORD_W; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {stage_reg[k].rem, stage_reg[k].quo[31]};
            ge    = (trial >= {1'b0, stage_reg[k].dsr});
            stage_next[k+1].side = stage_reg[k].side;
            stage_next[k+1].sat  = stage_reg[k].sat;
            stage_next[k+1].dsr  = stage_reg[k].dsr;
            stage_next[k+1].rem  = ge ? 32'(trial - {1'b0, stage_reg[k].dsr}) : trial[31:0];
            stage_next[k+1].quo  = {stage_reg[k].quo[30:0], ge};
        end
    end

    for (genvar k = 0; k <= atsc_pkg::WORD_W; k++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[k] <= '0;
            end
            else if (en)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign side_out = stage_reg[atsc_pkg::WORD_W].side;
    assign quot     = stage_reg[atsc_pkg::WORD_W].sat ? '1 : stage_reg[atsc_pkg::WORD_W].quo;

endmodule

`default_nettype wire

>>> hw/rtl/atsc_root.sv
`default_nettype none

module atsc_root (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire atsc_pkg::side_t side_in,
    input  wire logic [31:0]     t_in,
    output atsc_pkg::side_t      side_out,
    output logic [31:0]          t_out,
    output logic [19:0]          root
);

    typedef struct packed {
        atsc_pkg::side_t side;
        logic [31:0]     t;
        logic [19:0]     r;
        logic [39:0]     p2;
        logic [59:0]     p3;
        logic [79:0]     p4;
        logic [99:0]     p5;
    } rt_t;

    typedef struct packed {
        atsc_pkg::side_t side;
        logic [31:0]     t;
        logic [19:0]     r;
        logic [39:0]     p2;
        logic [59:0]     p3;
        logic [79:0]     p4;
        logic [99:0]     p5;
        logic [19:0]     c;
        logic [39:0]     c2;
        logic [59:0]     c3;
        logic [79:0]     c4;
        logic [99:0]     c5;
    } cand_t;

    rt_t   st_reg  [0:atsc_pkg::ROOT_BITS];
    rt_t   st_next [0:atsc_pkg::ROOT_BITS];
    cand_t cd_reg  [0:atsc_pkg::ROOT_BITS-1];
    cand_t cd_next [0:atsc_pkg::ROOT_BITS-1];

    // The fifth root of t * 2^64 stays below 2^20, so only the low 20 bits are tried.
    always_comb
    begin
        st_next[0].side = side_in;
        st_next[0].t    = t_in;
        st_next[0].r    = '0;
        st_next[0].p2   = '0;
        st_next[0].p3   = '0;
        st_next[0].p4   = '0;
        st_next[0].p5   = '0;
    end

    for (genvar k = 0; k < atsc_pkg::ROOT_BITS; k++)
    begin : g_bit
        localparam int unsigned B = atsc_pkg::ROOT_BITS - 1 - k;

        logic [39:0] w2a;
        logic [59:0] w3a;
        logic [59:0] w3b;
        logic [79:0] w4a;
        logic [79:0] w4b;
        logic [79:0] w4c;
        logic [99:0] w5a;
        logic [99:0] w5b;
        logic [99:0] w5c;
        logic [99:0] w5d;
        logic        fits;

        // Powers of r plus one new bit follow from the binomial expansion with shifts and adds.
        always_comb
        begin
            w2a = 40'(st_reg[k].r);
            w3a = 60'(st_reg[k].r);
            w3b = 60'(st_reg[k].p2);
            w4a = 80'(st_reg[k].r);
            w4b = 80'(st_reg[k].p2);
            w4c = 80'(st_reg[k].p3);
            w5a = 100'(st_reg[k].r);
            w5b = 100'(st_reg[k].p2);
            w5c = 100'(st_reg[k].p3);
            w5d = 100'(st_reg[k].p4);

            cd_next[k].side = st_reg[k].side;
            cd_next[k].t    = st_reg[k].t;
            cd_next[k].r    = st_reg[k].r;
            cd_next[k].p2   = st_reg[k].p2;
            cd_next[k].p3   = st_reg[k].p3;
            cd_next[k].p4   = st_reg[k].p4;
            cd_next[k].p5   = st_reg[k].p5;
            cd_next[k].c    = st_reg[k].r | (20'd1 << B);
            cd_next[k].c2   = st_reg[k].p2 + ((w2a << 1) << B) + (40'd1 << (2*B));
            cd_next[k].c3   = st_reg[k].p3 + (((w3b << 1) + w3b) << B)
                            + (((w3a << 1) + w3a) << (2*B)) + (60'd1 << (3*B));
            cd_next[k].c4   = st_reg[k].p4 + ((w4c << 2) << B)
                            + (((w4b << 2) + (w4b << 1)) << (2*B))
                            + ((w4a << 2) << (3*B)) + (80'd1 << (4*B));
            cd_next[k].c5   = st_reg[k].p5 + (((w5d << 2) + w5d) << B)
                            + (((w5c << 3) + (w5c << 1)) << (2*B))
                            + (((w5b << 3) + (w5b << 1)) << (3*B))
                            + (((w5a << 2) + w5a) << (4*B)) + (100'd1 << (5*B));
        end

        always_comb
        begin
            fits = (cd_reg[k].c5 <= {4'b0, cd_reg[k].t, 64'b0});
            st_next[k+1].side = cd_reg[k].side;
            st_next[k+1].t    = cd_reg[k].t;
            st_next[k+1].r    = fits ? cd_reg[k].c  : cd_reg[k].r;
            st_next[k+1].p2   = fits ? cd_reg[k].c2 : cd_reg[k].p2;
            st_next[k+1].p3   = fits ? cd_reg[k].c3 : cd_reg[k].p3;
            st_next[k+1].p4   = fits ? cd_reg[k].c4 : cd_reg[k].p4;
            st_next[k+1].p5   = fits ? cd_reg[k].c5 : cd_reg[k].p5;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_reg[k] <= '0;
            end
            else if (en)
            begin
                cd_reg[k] <= cd_next[k];
            end
        end
    end

    for (genvar k = 0; k <= atsc_pkg::ROOT_BITS; k++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg[k] <= '0;
            end
            else if (en)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign side_out = st_reg[atsc_pkg::ROOT_BITS].side;
    assign t_out    = st_reg[atsc_pkg::ROOT_BITS].t;
    assign root     = st_reg[atsc_pkg::ROOT_BITS].r;

`ifndef SYNTHESIS
    a_root_fits : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[atsc_pkg::ROOT_BITS].side.valid |->
        st_reg[atsc_pkg::ROOT_BITS].p5 <= {4'b0, st_reg[atsc_pkg::ROOT_BITS].t, 64'b0})
        else $error("root power exceeds radicand");
    a_root_square : assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[atsc_pkg::ROOT_BITS].side.valid |->
        st_reg[atsc_pkg::ROOT_BITS].p2 ==
        40'(st_reg[atsc_pkg::ROOT_BITS].r) * 40'(st_reg[atsc_pkg::ROOT_BITS].r))
        else $error("tracked square out of step with root");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/atsc_post.sv
`default_nettype none

module atsc_post (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire atsc_pkg::bounds_t bounds,
    input  wire atsc_pkg::side_t   side_in,
    input  wire logic [31:0]       q_in,
    input  wire logic [19:0]       root,
    output logic                   out_valid,
    output logic [31:0]            new_step
);

    function automatic logic [31:0] clamp_step(input logic [31:0] x,
                                               input logic [31:0] lo,
                                               input logic [31:0] hi);
        logic [31:0] y;
        y = (x < lo) ? lo : x;
        return (y > hi) ? hi : y;
    endfunction

    atsc_pkg::side_t s1_side_reg;
    logic [31:0]     s1_q_reg;
    logic [35:0]     s1_f_reg;
    atsc_pkg::side_t s2_side_reg;
    logic [31:0]     s2_q_reg;
    logic [49:0]     s2_prod_reg;
    logic            out_valid_reg;
    logic [31:0]     new_step_reg;

    logic [19:0]     f_raw;
    logic [17:0]     f_clamped;
    logic [49:0]     prod_next;
    logic [33:0]     p_shift;
    logic [31:0]     p_sat;
    logic [32:0]     doubled;
    logic [31:0]     new_step_next;

    always_comb
    begin
        f_raw     = s1_f_reg[35:16];
        if (f_raw < 20'(atsc_pkg::FACTOR_LOW_Q))
        begin
            f_clamped = atsc_pkg::FACTOR_LOW_Q;
        end
        else if (f_raw > 20'(atsc_pkg::FACTOR_HIGH_Q))
        begin
            f_clamped = atsc_pkg::FACTOR_HIGH_Q;
        end
        else
        begin
            f_clamped = f_raw[17:0];
        end
        prod_next = 50'(f_clamped) * 50'(s1_side_reg.cur);
    end

    always_comb
    begin
        p_shift = s2_prod_reg[49:16];
        p_sat   = (p_shift[33:32] != 2'b00) ? '1 : p_shift[31:0];
        doubled = {s2_side_reg.cur, 1'b0};
        if (!s2_side_reg.mode)
        begin
            new_step_next = s2_side_reg.zero ? bounds.step_maximum
                          : clamp_step(s2_q_reg, bounds.step_minimum, bounds.step_maximum);
        end
        else if (s2_side_reg.zero)
        begin
            new_step_next = (doubled < {1'b0, bounds.step_maximum}) ? doubled[31:0]
                          : bounds.step_maximum;
        end
        else
        begin
            new_step_next = clamp_step(p_sat, bounds.step_minimum, bounds.step_maximum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg   <= '0;
            s2_side_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_side_reg   <= side_in;
            s2_side_reg   <= s1_side_reg;
            out_valid_reg <= s2_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_q_reg     <= q_in;
            s1_f_reg     <= 36'(root) * 36'(atsc_pkg::NINE_TENTHS_Q);
            s2_q_reg     <= s1_q_reg;
            s2_prod_reg  <= prod_next;
            new_step_reg <= new_step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_step  = new_step_reg;

endmodule

`default_nettype wire

>>> hw/rtl/adaptive_time_step_control_core.sv
`default_nettype none

// Adaptive time-step unit: every input item yields one new step, CFL rule (tuser 0) or
// error rule (tuser 1), all values unsigned Q16.16. It is a fixed pipeline of 78 stages:
// one input stage with the 32x32 multiply, 33 stages of a radix-2 divider, 41 stages of a
// bit-by-bit fifth root (an entry stage and two per root bit) and three stages of scaling
// and clamping. It takes one item per cycle; the whole pipeline holds while a result
// is offered and not taken. Configuration writes are always ready and should only be made
// while no item is in flight.

module adaptive_time_step_control_core (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cell_size, peak_speed, current_step, error_estimate, error_tolerance (from bit 0)
    input  wire logic [159:0] s_tdata,
    // mode
    input  wire logic [0:0]   s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_step
    output logic [31:0]       m_tdata,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic [31:0] step_minimum_reg;
    logic [31:0] step_maximum_reg;
    logic [31:0] safety_factor_reg;

    logic        en;
    logic [31:0] cell_size;
    logic [31:0] peak_speed;
    logic [31:0] current_step;
    logic [31:0] error_estimate;
    logic [31:0] error_tolerance;

    atsc_pkg::side_t   in_side_next;
    atsc_pkg::side_t   in_side_reg;
    logic [63:0]       dividend_next;
    logic [63:0]       dividend_reg;
    logic [31:0]       divisor_next;
    logic [31:0]       divisor_reg;

    atsc_pkg::side_t   div_side;
    logic [31:0]       quot;
    atsc_pkg::side_t   root_side;
    logic [31:0]       root_t;
    logic [19:0]       root;
    atsc_pkg::bounds_t bounds;
    logic              out_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_minimum_reg  <= atsc_pkg::STEP_MIN_RESET;
            step_maximum_reg  <= atsc_pkg::STEP_MAX_RESET;
            safety_factor_reg <= atsc_pkg::SAFETY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                atsc_pkg::CFG_STEP_MIN: step_minimum_reg  <= cfg_data;
                atsc_pkg::CFG_STEP_MAX: step_maximum_reg  <= cfg_data;
                atsc_pkg::CFG_SAFETY:   safety_factor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    assign cell_size       = s_tdata[31:0];
    assign peak_speed      = s_tdata[63:32];
    assign current_step    = s_tdata[95:64];
    assign error_estimate  = s_tdata[127:96];
    assign error_tolerance = s_tdata[159:128];

    // Both rules share the divider; a zero divisor is replaced since its item bypasses the quotient.
    always_comb
    begin
        in_side_next.valid = s_tvalid;
        in_side_next.mode  = s_tuser[0];
        in_side_next.cur   = current_step;
        if (!s_tuser[0])
        begin
            in_side_next.zero = (peak_speed == '0);
            dividend_next     = 64'(safety_factor_reg) * 64'(cell_size);
            divisor_next      = peak_speed;
        end
        else
        begin
            in_side_next.zero = (error_estimate == '0);
            dividend_next     = {16'b0, error_tolerance, 16'b0};
            divisor_next      = error_estimate;
        end
        if (in_side_next.zero)
        begin
            divisor_next = 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_side_reg <= '0;
        end
        else if (en)
        begin
            in_side_reg <= in_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dividend_reg <= dividend_next;
            divisor_reg  <= divisor_next;
        end
    end

    atsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (in_side_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .side_out (div_side),
        .quot     (quot)
    );

    atsc_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (div_side),
        .t_in     (quot),
        .side_out (root_side),
        .t_out    (root_t),
        .root     (root)
    );

    assign bounds.step_minimum = step_minimum_reg;
    assign bounds.step_maximum = step_maximum_reg;

    atsc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .bounds    (bounds),
        .side_in   (root_side),
        .q_in      (root_t),
        .root      (root),
        .out_valid (out_valid),
        .new_step  (m_tdata)
    );

    assign m_tvalid = out_valid;

`ifndef SYNTHESIS
    a_step_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= step_maximum_reg)
        else $error("result above the largest step");
    a_zero_speed : assert property (@(posedge clk) disable iff (!rst_n)
        (in_side_reg.valid && in_side_reg.zero) |-> divisor_reg == 32'd1)
        else $error("zero divisor entered the divider");
`endif

endmodule

`default_nettype wire
